@@ rtl/core/clock_time_set_and_alarm_assert.svh @@
// assertion macros for the clock time-set and alarm block
`ifndef CLOCK_TIME_SET_AND_ALARM_ASSERT_SVH
`define CLOCK_TIME_SET_AND_ALARM_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define CTSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CTSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CTSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define CTSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/core/ctsa_pkg.sv @@
`default_nettype none

package ctsa_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_ADJUST = 3'b010,
        MODE_ALARM  = 3'b100
    } t_mode;

    // external mode codes on mode_now
    localparam logic [1:0] MODE_CODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_CODE_ADJUST = 2'd1;
    localparam logic [1:0] MODE_CODE_ALARM  = 2'd2;

    // cursor positions in time adjust
    localparam logic [2:0] ADJ_HOUR   = 3'd0;
    localparam logic [2:0] ADJ_MINUTE = 3'd1;
    localparam logic [2:0] ADJ_SECOND = 3'd2;
    localparam logic [2:0] ADJ_DATE   = 3'd3;
    localparam logic [2:0] ADJ_MONTH  = 3'd4;
    localparam logic [2:0] ADJ_YEAR   = 3'd5;

    // cursor positions in alarm set
    localparam logic [2:0] ALM_ENABLE = 3'd0;
    localparam logic [2:0] ALM_HOUR   = 3'd1;
    localparam logic [2:0] ALM_MINUTE = 3'd2;
    localparam logic [2:0] ALM_SECOND = 3'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_ALARM_BCD  = 2'd0;
    localparam logic [1:0] CFG_ALARM_EN   = 2'd1;
    localparam logic [1:0] CFG_LAMP_TICKS = 2'd2;

    localparam logic [15:0] LAMP_TICKS_RESET = 16'd33334;

    // field limits
    localparam logic [7:0] MAX_HOUR   = 8'd23;
    localparam logic [7:0] MAX_MINSEC = 8'd59;
    localparam logic [7:0] MAX_MONTH  = 8'd12;
    localparam logic [7:0] MAX_YEAR   = 8'd99;
    localparam logic [7:0] MIN_ZERO   = 8'd0;
    localparam logic [7:0] MIN_ONE    = 8'd1;
    localparam logic [7:0] DAYS_LEAP  = 8'd29;
    localparam logic [7:0] DAYS_FEB   = 8'd28;
    localparam logic [7:0] DAYS_SHORT = 8'd30;
    localparam logic [7:0] DAYS_LONG  = 8'd31;

    localparam logic [7:0] MONTH_FEB = 8'd2;
    localparam logic [7:0] MONTH_APR = 8'd4;
    localparam logic [7:0] MONTH_JUN = 8'd6;
    localparam logic [7:0] MONTH_SEP = 8'd9;
    localparam logic [7:0] MONTH_NOV = 8'd11;

    // byte read as high nibble * 10 + low nibble
    function automatic logic [7:0] bcd_val(input logic [7:0] b);
        logic [7:0] hi;
        hi = 8'(b[7:4]);
        return (hi << 3) + (hi << 1) + 8'(b[3:0]);
    endfunction

    // step one bcd byte, wrap to lo at or above hi
    function automatic logic [7:0] bcd_step(input logic [7:0] b, input logic [7:0] lo,
                                            input logic [7:0] hi);
        logic [7:0]  v;
        logic [15:0] prod;
        logic [3:0]  tens;
        logic [7:0]  ones;
        v = bcd_val(b);
        v = (v >= hi) ? lo : v + 8'd1;
        // v stays below 100 here, so v*205>>11 is v/10
        prod = (16'(v) << 7) + (16'(v) << 6) + (16'(v) << 3) + (16'(v) << 2)
             + 16'(v);
        tens = prod[14:11];
        ones = v - ((8'(tens) << 3) + (8'(tens) << 1));
        return {tens, ones[3:0]};
    endfunction

    function automatic logic [7:0] month_len(input logic [7:0] month,
                                             input logic [7:0] year);
        logic [7:0] len;
        case (month) inside
            MONTH_FEB: len = (year[1:0] == 2'd0) ? DAYS_LEAP : DAYS_FEB;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_SHORT;
            default: len = DAYS_LONG;
        endcase
        return len;
    endfunction

    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] c;
        unique case (m)
            MODE_ADJUST: c = MODE_CODE_ADJUST;
            MODE_ALARM:  c = MODE_CODE_ALARM;
            default:     c = MODE_CODE_NORMAL;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/ctsa_in_if.sv @@
`default_nettype none

interface ctsa_in_if;
    logic        valid;
    logic        ready;
    logic        mode_button;
    logic        cursor_button;
    logic        value_button;
    logic        set_button;
    logic [47:0] rtc_time_bcd;
    logic        tick;

    modport source (
        output valid, mode_button, cursor_button, value_button, set_button,
               rtc_time_bcd, tick,
        input  ready
    );

    modport sink (
        input  valid, mode_button, cursor_button, value_button, set_button,
               rtc_time_bcd, tick,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/ctsa_out_if.sv @@
`default_nettype none

interface ctsa_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode_now;
    logic [2:0]  cursor;
    logic [47:0] edit_time_bcd;
    logic [23:0] alarm_time_bcd;
    logic        alarm_enable;
    logic        lamp_on;
    logic        write_time;
    logic        write_alarm;

    modport source (
        output valid, mode_now, cursor, edit_time_bcd, alarm_time_bcd, alarm_enable,
               lamp_on, write_time, write_alarm,
        input  ready
    );

    modport sink (
        input  valid, mode_now, cursor, edit_time_bcd, alarm_time_bcd, alarm_enable,
               lamp_on, write_time, write_alarm,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/clock_time_set_and_alarm.sv @@
// Time-set and alarm controller for a four-button digital clock.
// i_in carries one poll per transfer: button levels, the clock's BCD time
// and date, and a timebase tick. o_out carries one result per poll: mode,
// cursor, edit buffer, alarm time and enable, lamp and the two write strobes.
// Latency: the result of a poll is valid in the cycle after its transfer.
// Throughput: one poll per cycle; the state registers hold the result, and
// a new poll is taken in the same cycle that the pending result is taken.
// If the receiver stalls, the result holds and i_in.ready stays low until
// o_out.ready rises; no poll is lost.
// Reset (synchronous, active low) puts the block in normal mode with the
// cursor and edit buffer at zero, the lamp out, the alarm time and enable at
// zero and the lamp timeout at 33334 ticks. No clearing pass is needed.
// Configuration writes on i_cfg_* take effect at once: the alarm time and
// enable registers load the alarm state directly; the user must write only
// while no poll is in flight, as the block itself does not enforce it.
`default_nettype none

`include "clock_time_set_and_alarm_assert.svh"

module clock_time_set_and_alarm
    import ctsa_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire  [1:0]   i_cfg_index,
    input  wire  [23:0]  i_cfg_data,
    ctsa_in_if.sink      i_in,
    ctsa_out_if.source   o_out
);

    logic [3:0]  r_prior;
    t_mode       r_mode;
    logic [2:0]  r_cursor;
    logic [47:0] r_edit;
    logic [23:0] r_alarm_time;
    logic        r_armed;
    logic        r_lamp;
    logic [15:0] r_lamp_cnt;
    logic        r_lamp_counting;
    logic [15:0] r_lamp_ticks;
    logic        r_wr_time;
    logic        r_wr_alarm;
    logic        r_out_valid;

    t_mode       n_mode;
    logic [2:0]  n_cursor;
    logic [47:0] n_edit;
    logic [23:0] n_alarm_time;
    logic        n_armed;
    logic        n_lamp;
    logic [15:0] n_lamp_cnt;
    logic        n_lamp_counting;
    logic        n_wr_time;
    logic        n_wr_alarm;

    logic [3:0]  btn_now;
    logic [3:0]  rise;
    logic        in_xfer;
    logic [15:0] cnt_inc;
    logic [7:0]  date_lim;

    assign btn_now = {i_in.set_button, i_in.value_button, i_in.cursor_button,
                      i_in.mode_button};
    assign rise    = btn_now & ~r_prior;
    assign in_xfer = i_in.valid && i_in.ready;
    assign cnt_inc = r_lamp_cnt + 16'd1;

    // the state registers are the result register
    assign i_in.ready = !r_out_valid || o_out.ready;

    always_comb begin
        n_mode          = r_mode;
        n_cursor        = r_cursor;
        n_edit          = r_edit;
        n_alarm_time    = r_alarm_time;
        n_armed         = r_armed;
        n_lamp          = r_lamp;
        n_lamp_cnt      = r_lamp_cnt;
        n_lamp_counting = r_lamp_counting;
        n_wr_time       = 1'b0;
        n_wr_alarm      = 1'b0;
        date_lim        = DAYS_LONG;

        // lamp timeout
        if (r_lamp_counting && i_in.tick) begin
            n_lamp_cnt = cnt_inc;
            if (cnt_inc >= r_lamp_ticks) begin
                n_lamp          = 1'b0;
                n_lamp_counting = 1'b0;
                n_lamp_cnt      = '0;
            end
        end

        if (rise[0]) begin
            unique case (r_mode)
                MODE_NORMAL: begin
                    n_mode   = MODE_ADJUST;
                    n_cursor = ADJ_HOUR;
                    n_edit   = i_in.rtc_time_bcd;
                end
                MODE_ADJUST: begin
                    n_mode   = MODE_ALARM;
                    n_cursor = ALM_ENABLE;
                end
                default: n_mode = MODE_NORMAL;
            endcase
        end

        unique case (n_mode)
            MODE_NORMAL: begin
                if (r_armed && (i_in.rtc_time_bcd[47:24] == r_alarm_time)) begin
                    n_lamp = 1'b1;
                    // a timeout in this same poll lets a held match restart the count
                    if (!n_lamp_counting) begin
                        n_lamp_counting = 1'b1;
                        n_lamp_cnt      = '0;
                    end
                end
                if (rise[3]) begin
                    n_lamp          = 1'b0;
                    n_lamp_counting = 1'b0;
                    n_lamp_cnt      = '0;
                end
            end
            MODE_ADJUST: begin
                // set acts on the level here
                if (btn_now[3]) begin
                    n_wr_time = 1'b1;
                    n_mode    = MODE_NORMAL;
                end else begin
                    if (rise[1]) begin
                        n_cursor = (n_cursor >= ADJ_YEAR) ? ADJ_HOUR : n_cursor + 3'd1;
                    end
                    date_lim = month_len(bcd_val(n_edit[15:8]), bcd_val(n_edit[7:0]));
                    if (rise[2]) begin
                        case (n_cursor)
                            ADJ_MINUTE: n_edit[39:32] =
                                bcd_step(n_edit[39:32], MIN_ZERO, MAX_MINSEC);
                            ADJ_SECOND: n_edit[31:24] =
                                bcd_step(n_edit[31:24], MIN_ZERO, MAX_MINSEC);
                            ADJ_DATE:   n_edit[23:16] =
                                bcd_step(n_edit[23:16], MIN_ONE, date_lim);
                            ADJ_MONTH:  n_edit[15:8] =
                                bcd_step(n_edit[15:8], MIN_ONE, MAX_MONTH);
                            ADJ_YEAR:   n_edit[7:0] =
                                bcd_step(n_edit[7:0], MIN_ZERO, MAX_YEAR);
                            default:    n_edit[47:40] =
                                bcd_step(n_edit[47:40], MIN_ZERO, MAX_HOUR);
                        endcase
                    end
                end
            end
            MODE_ALARM: begin
                if (rise[1]) begin
                    n_cursor = (n_cursor >= ALM_SECOND) ? ALM_ENABLE : n_cursor + 3'd1;
                end
                if (rise[2]) begin
                    case (n_cursor)
                        ALM_HOUR:   n_alarm_time[23:16] =
                            bcd_step(r_alarm_time[23:16], MIN_ZERO, MAX_HOUR);
                        ALM_MINUTE: n_alarm_time[15:8] =
                            bcd_step(r_alarm_time[15:8], MIN_ZERO, MAX_MINSEC);
                        ALM_SECOND: n_alarm_time[7:0] =
                            bcd_step(r_alarm_time[7:0], MIN_ZERO, MAX_MINSEC);
                        default:    n_armed = !r_armed;
                    endcase
                end
                if (rise[3]) begin
                    n_wr_alarm = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior         <= '0;
            r_mode          <= MODE_NORMAL;
            r_cursor        <= '0;
            r_edit          <= '0;
            r_alarm_time    <= '0;
            r_armed         <= 1'b0;
            r_lamp          <= 1'b0;
            r_lamp_cnt      <= '0;
            r_lamp_counting <= 1'b0;
            r_lamp_ticks    <= LAMP_TICKS_RESET;
            r_wr_time       <= 1'b0;
            r_wr_alarm      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_prior         <= btn_now;
                r_mode          <= n_mode;
                r_cursor        <= n_cursor;
                r_edit          <= n_edit;
                r_alarm_time    <= n_alarm_time;
                r_armed         <= n_armed;
                r_lamp          <= n_lamp;
                r_lamp_cnt      <= n_lamp_cnt;
                r_lamp_counting <= n_lamp_counting;
                r_wr_time       <= n_wr_time;
                r_wr_alarm      <= n_wr_alarm;
                r_out_valid     <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ALARM_BCD:  r_alarm_time <= i_cfg_data;
                    CFG_ALARM_EN:   r_armed      <= i_cfg_data[0];
                    CFG_LAMP_TICKS: r_lamp_ticks <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.mode_now       = mode_code(r_mode);
    assign o_out.cursor         = r_cursor;
    assign o_out.edit_time_bcd  = r_edit;
    assign o_out.alarm_time_bcd = r_alarm_time;
    assign o_out.alarm_enable   = r_armed;
    assign o_out.lamp_on        = r_lamp;
    assign o_out.write_time     = r_wr_time;
    assign o_out.write_alarm    = r_wr_alarm;

    `CTSA_ASSERT_IMP(a_one_strobe, i_clk, i_rst_n, r_wr_time, !r_wr_alarm, "two strobes")
    `CTSA_ASSERT_IMP(a_lamp_count, i_clk, i_rst_n, !r_lamp, !r_lamp_counting, "timer while unlit")
    `CTSA_ASSERT_IMP(a_wr_time_mode, i_clk, i_rst_n, r_wr_time, r_mode == MODE_NORMAL, "bad mode")
    `CTSA_ASSERT_IMP(a_wr_alarm_mode, i_clk, i_rst_n, r_wr_alarm, r_mode == MODE_ALARM, "bad mode")
    `CTSA_ASSERT_NXT(a_result_after_xfer, i_clk, i_rst_n, in_xfer, r_out_valid, "no result")

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import ctsa_pkg::*;

    // button level vectors, packed {set, value, cursor, mode}
    localparam int B_MODE   = 0;
    localparam int B_CURSOR = 1;
    localparam int B_VALUE  = 2;
    localparam int B_SET    = 3;
    localparam logic [3:0] BTN_NONE   = 4'b0000;
    localparam logic [3:0] BTN_MODE   = 4'b0001;
    localparam logic [3:0] BTN_CURSOR = 4'b0010;
    localparam logic [3:0] BTN_VALUE  = 4'b0100;
    localparam logic [3:0] BTN_SET    = 4'b1000;

    // index past the register list, ignored by the block
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam int HOLD_CYCLES = 150;

    typedef struct {
        logic        mode_b;
        logic        cursor_b;
        logic        value_b;
        logic        set_b;
        logic [47:0] rtc;
        logic        tick;
    } t_poll;

    typedef struct {
        logic [1:0]  mode_now;
        logic [2:0]  cursor;
        logic [47:0] edit_time;
        logic [23:0] alarm_time;
        logic        alarm_en;
        logic        lamp_on;
        logic        write_time;
        logic        write_alarm;
    } t_status;

    function automatic logic [7:0] to_bcd(int v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    function automatic int bcd_value(logic [7:0] b);
        return int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    class time_set_tracker;
        logic [23:0] cfg_alarm;
        logic        cfg_alarm_en;
        logic [15:0] cfg_lamp_ticks;

        logic [3:0]  prev_btns;
        logic [1:0]  mode;
        logic [2:0]  cur;
        logic [47:0] edit;
        logic [23:0] alarm_bcd;
        logic        armed;
        logic        lamp;
        logic [15:0] lamp_cnt;
        logic        lamp_run;

        t_status     expected_status[$];
        int          errors;

        function new();
            cfg_alarm      = '0;
            cfg_alarm_en   = 1'b0;
            cfg_lamp_ticks = LAMP_TICKS_RESET;
            prev_btns      = '0;
            mode           = MODE_CODE_NORMAL;
            cur            = ADJ_HOUR;
            edit           = '0;
            alarm_bcd      = cfg_alarm;
            armed          = cfg_alarm_en;
            lamp           = 1'b0;
            lamp_cnt       = '0;
            lamp_run       = 1'b0;
            errors         = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [23:0] data);
            case (idx)
                CFG_ALARM_BCD: begin
                    cfg_alarm = data;
                    alarm_bcd = data;
                end
                CFG_ALARM_EN: begin
                    cfg_alarm_en = data[0];
                    armed        = data[0];
                end
                CFG_LAMP_TICKS: cfg_lamp_ticks = data[15:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] bcd_inc(logic [7:0] b, int lo, int hi);
            int v;
            v = bcd_value(b);
            v = (v >= hi) ? lo : v + 1;
            return to_bcd(v);
        endfunction

        function int month_days(logic [7:0] mo_b, logic [7:0] yr_b);
            int mo;
            mo = bcd_value(mo_b);
            if (mo == 2) return (bcd_value(yr_b) % 4 == 0) ? 29 : 28;
            if (mo == 4 || mo == 6 || mo == 9 || mo == 11) return 30;
            return 31;
        endfunction

        function void take_poll(t_poll p);
            logic [3:0] levels;
            logic [3:0] rise;
            t_status    s;
            int         k;
            int         lo;
            int         hi;
            levels = {p.set_b, p.value_b, p.cursor_b, p.mode_b};
            rise = levels & ~prev_btns;
            prev_btns = levels;
            s.write_time = 1'b0;
            s.write_alarm = 1'b0;

            if (lamp_run && p.tick) begin
                lamp_cnt = lamp_cnt + 16'd1;
                if (lamp_cnt >= cfg_lamp_ticks) begin
                    lamp = 1'b0;
                    lamp_run = 1'b0;
                    lamp_cnt = '0;
                end
            end

            if (rise[B_MODE]) begin
                case (mode)
                    MODE_CODE_NORMAL: begin
                        mode = MODE_CODE_ADJUST;
                        cur = ADJ_HOUR;
                        edit = p.rtc;
                    end
                    MODE_CODE_ADJUST: begin
                        mode = MODE_CODE_ALARM;
                        cur = ALM_ENABLE;
                    end
                    default: mode = MODE_CODE_NORMAL;
                endcase
            end

            if (mode == MODE_CODE_NORMAL) begin
                if (armed && p.rtc[47:24] == alarm_bcd) begin
                    lamp = 1'b1;
                    if (!lamp_run) begin
                        lamp_run = 1'b1;
                        lamp_cnt = '0;
                    end
                end
                if (rise[B_SET]) begin
                    lamp = 1'b0;
                    lamp_run = 1'b0;
                    lamp_cnt = '0;
                end
            end else if (mode == MODE_CODE_ADJUST) begin
                // set commits on its level and swallows this poll's edits
                if (p.set_b) begin
                    s.write_time = 1'b1;
                    mode = MODE_CODE_NORMAL;
                end else begin
                    if (rise[B_CURSOR]) cur = (cur >= ADJ_YEAR) ? ADJ_HOUR : cur + 3'd1;
                    if (rise[B_VALUE]) begin
                        lo = 0;
                        case (cur)
                            ADJ_MINUTE: begin k = 1; hi = 59; end
                            ADJ_SECOND: begin k = 2; hi = 59; end
                            ADJ_DATE: begin
                                k = 3;
                                lo = 1;
                                hi = month_days(edit[15:8], edit[7:0]);
                            end
                            ADJ_MONTH: begin k = 4; lo = 1; hi = 12; end
                            ADJ_YEAR: begin k = 5; hi = 99; end
                            default: begin k = 0; hi = 23; end
                        endcase
                        edit[47 - 8 * k -: 8] = bcd_inc(edit[47 - 8 * k -: 8], lo, hi);
                    end
                end
            end else if (mode == MODE_CODE_ALARM) begin
                if (rise[B_CURSOR]) cur = (cur >= ALM_SECOND) ? ALM_ENABLE : cur + 3'd1;
                if (rise[B_VALUE]) begin
                    case (cur)
                        ALM_HOUR:   alarm_bcd[23:16] = bcd_inc(alarm_bcd[23:16], 0, 23);
                        ALM_MINUTE: alarm_bcd[15:8] = bcd_inc(alarm_bcd[15:8], 0, 59);
                        ALM_SECOND: alarm_bcd[7:0] = bcd_inc(alarm_bcd[7:0], 0, 59);
                        default:    armed = ~armed;
                    endcase
                end
                if (rise[B_SET]) s.write_alarm = 1'b1;
            end

            s.mode_now = mode;
            s.cursor = cur;
            s.edit_time = edit;
            s.alarm_time = alarm_bcd;
            s.alarm_en = armed;
            s.lamp_on = lamp;
            expected_status.push_back(s);
        endfunction

        function void compare(string name, logic [47:0] want, logic [47:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t status mismatch on %s: expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_status(t_status got);
            t_status want;
            if (expected_status.size() == 0) begin
                errors++;
                $display("%0t status transfer with no poll pending", $time);
                return;
            end
            want = expected_status.pop_front();
            compare("mode_now", 48'(want.mode_now), 48'(got.mode_now));
            compare("cursor", 48'(want.cursor), 48'(got.cursor));
            compare("edit_time_bcd", want.edit_time, got.edit_time);
            compare("alarm_time_bcd", 48'(want.alarm_time), 48'(got.alarm_time));
            compare("alarm_enable", 48'(want.alarm_en), 48'(got.alarm_en));
            compare("lamp_on", 48'(want.lamp_on), 48'(got.lamp_on));
            compare("write_time", 48'(want.write_time), 48'(got.write_time));
            compare("write_alarm", 48'(want.write_alarm), 48'(got.write_alarm));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [23:0] i_cfg_data;

    ctsa_in_if  poll_if ();
    ctsa_out_if status_if ();

    clock_time_set_and_alarm i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (poll_if),
        .o_out       (status_if)
    );

    time_set_tracker tracker;
    bit              no_idle;
    bit              hold_request;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_poll make_poll(logic [3:0] btns, logic [47:0] rtc, logic tick);
        t_poll p;
        p.mode_b = btns[B_MODE];
        p.cursor_b = btns[B_CURSOR];
        p.value_b = btns[B_VALUE];
        p.set_b = btns[B_SET];
        p.rtc = rtc;
        p.tick = tick;
        return p;
    endfunction

    function automatic logic [23:0] random_hms();
        return {to_bcd($urandom_range(0, 23)), to_bcd($urandom_range(0, 59)),
                to_bcd($urandom_range(0, 59))};
    endfunction

    function automatic t_poll random_poll();
        int          r;
        logic [3:0]  btns;
        logic [47:0] rtc;
        r = $urandom_range(0, 99);
        if (r < 45) btns = BTN_NONE;
        else if (r < 60) btns = BTN_CURSOR;
        else if (r < 78) btns = BTN_VALUE;
        else if (r < 88) btns = BTN_MODE;
        else if (r < 93) btns = BTN_SET;
        else btns = 4'($urandom);
        rtc = {random_hms(), to_bcd($urandom_range(0, 31)), to_bcd($urandom_range(0, 13)),
               to_bcd($urandom_range(0, 99))};
        r = $urandom_range(0, 99);
        // hit the alarm time often enough to light and time out the lamp
        if (r < 20) rtc[47:24] = tracker.alarm_bcd;
        else if (r >= 85) rtc = {16'($urandom), 32'($urandom)};
        return make_poll(btns, rtc, 1'($urandom_range(0, 1)));
    endfunction

    task automatic send_poll(t_poll p);
        repeat (pick_gap()) begin
            @(negedge i_clk);
            poll_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        poll_if.valid <= 1'b1;
        poll_if.mode_button <= p.mode_b;
        poll_if.cursor_button <= p.cursor_b;
        poll_if.value_button <= p.value_b;
        poll_if.set_button <= p.set_b;
        poll_if.rtc_time_bcd <= p.rtc;
        poll_if.tick <= p.tick;
        do @(posedge i_clk); while (!poll_if.ready);
        tracker.take_poll(p);
    endtask

    // stop offering polls and wait for every status to come back
    task automatic settle();
        @(negedge i_clk);
        poll_if.valid <= 1'b0;
        while (tracker.expected_status.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        status_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = pick_gap();
            end
            repeat (stall) begin
                @(negedge i_clk);
                status_if.ready <= 1'b0;
            end
            repeat ($urandom_range(1, 8)) begin
                @(negedge i_clk);
                status_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : status_monitor
        t_status got;
        if (i_rst_n && status_if.valid && status_if.ready) begin
            got.mode_now = status_if.mode_now;
            got.cursor = status_if.cursor;
            got.edit_time = status_if.edit_time_bcd;
            got.alarm_time = status_if.alarm_time_bcd;
            got.alarm_en = status_if.alarm_enable;
            got.lamp_on = status_if.lamp_on;
            got.write_time = status_if.write_time;
            got.write_alarm = status_if.write_alarm;
            tracker.check_status(got);
        end
    end

    // ~830 polls in all
    initial begin
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        logic [47:0] dir_rtc;
        tracker = new();
        no_idle = 1'b0;
        hold_request = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        poll_if.valid = 1'b0;
        poll_if.mode_button = 1'b0;
        poll_if.cursor_button = 1'b0;
        poll_if.value_button = 1'b0;
        poll_if.set_button = 1'b0;
        poll_if.rtc_time_bcd = '0;
        poll_if.tick = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: hour, minute, second and date at their tops in a leap february (year 00), then non-bcd bytes
        dir_rtc = 48'h235959_290200;
        send_poll(make_poll(BTN_NONE, '1, 1'b1));
        send_poll(make_poll(BTN_MODE, dir_rtc, 1'b0));
        send_poll(make_poll(BTN_VALUE, dir_rtc, 1'b1));
        repeat (5) begin
            send_poll(make_poll(BTN_CURSOR, dir_rtc, 1'b0));
            send_poll(make_poll(BTN_VALUE, dir_rtc, 1'b1));
        end
        send_poll(make_poll(BTN_CURSOR, dir_rtc, 1'b0));
        send_poll(make_poll(BTN_VALUE, dir_rtc, 1'b0));
        // commit on set level; the cursor edge of the same transfer is dropped
        send_poll(make_poll(BTN_SET | BTN_CURSOR | BTN_VALUE, dir_rtc, 1'b0));
        send_poll(make_poll(BTN_MODE, '1, 1'b0));
        send_poll(make_poll(BTN_VALUE, '1, 1'b0));
        send_poll(make_poll(BTN_MODE, dir_rtc, 1'b0));
        send_poll(make_poll(BTN_VALUE, dir_rtc, 1'b0));
        send_poll(make_poll(BTN_CURSOR, dir_rtc, 1'b0));
        send_poll(make_poll(BTN_VALUE, dir_rtc, 1'b0));
        send_poll(make_poll(BTN_SET, dir_rtc, 1'b0));
        send_poll(make_poll(BTN_MODE, {tracker.alarm_bcd, 24'h010199}, 1'b0));
        send_poll(make_poll(BTN_NONE, dir_rtc, 1'b1));
        send_poll(make_poll(BTN_SET, dir_rtc, 1'b1));

        for (int ph = 0; ph < 8; ph++) begin
            settle();
            case (ph)
                0: begin
                    write_reg(CFG_ALARM_BCD, 24'h000000);
                    write_reg(CFG_ALARM_EN, 24'h000001);
                    write_reg(CFG_LAMP_TICKS, 24'h000001);
                end
                1: begin
                    write_reg(CFG_ALARM_BCD, 24'h235959);
                    // zero ticks acts as one; upper data bits are dropped
                    write_reg(CFG_LAMP_TICKS, 24'hA50000);
                end
                2: begin
                    write_reg(CFG_ALARM_BCD, 24'hFFFFFF);
                    write_reg(CFG_ALARM_EN, 24'hFFFFFE);
                    write_reg(CFG_LAMP_TICKS, 24'h00FFFF);
                end
                3: begin
                    write_reg(CFG_ALARM_BCD, random_hms());
                    write_reg(CFG_ALARM_EN, 24'h000001);
                    write_reg(CFG_LAMP_TICKS, 24'h000003);
                end
                4: begin
                    write_reg(CFG_ALARM_BCD, random_hms());
                    write_reg(CFG_LAMP_TICKS, 24'h000002);
                    hold_request = 1'b1;
                end
                5: begin
                    write_reg(CFG_ALARM_BCD, 24'($urandom));
                    write_reg(CFG_LAMP_TICKS, 24'h000005);
                end
                6: begin
                    write_reg(CFG_UNUSED, 24'($urandom));
                    write_reg(CFG_ALARM_BCD, random_hms());
                    write_reg(CFG_LAMP_TICKS, 24'(LAMP_TICKS_RESET));
                end
                default: begin
                    write_reg(CFG_ALARM_EN, 24'h000000);
                    write_reg(CFG_ALARM_EN, 24'h000001);
                    write_reg(CFG_ALARM_BCD, random_hms());
                    write_reg(CFG_LAMP_TICKS, 24'h000001);
                end
            endcase
            no_idle = (ph == 5);
            for (int n = 0; n < 100; n++) begin
                if (ph == 3 && n == 50) settle();
                send_poll(random_poll());
            end
        end

        settle();
        repeat (4) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.expected_status.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
